[hdl/indexed_doubly_linked_list_core_macros.svh]
// Assertion macros shared by the linked list checker.
`ifndef INDEXED_DOUBLY_LINKED_LIST_CORE_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IDLL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IDLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/idll_pkg.sv]
// Types, constants and microcode ROM of the indexed doubly linked list core.
`timescale 1ns / 1ps

package idll_pkg;

    localparam int NODE_CAPACITY = 1024;
    localparam int NODE_W        = 11;
    localparam int ADDR_W        = $clog2(NODE_CAPACITY);
    localparam int STEP_W        = 4;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [STEP_W-1:0] step_t;

    localparam node_t NODE_COUNT_RESET = NODE_W'(1024);

    typedef enum logic [1:0] {
        REQ_UNLINK,
        REQ_BEFORE,
        REQ_AFTER,
        REQ_QUERY
    } req_t;

    // Sources for the read node, link addresses, link data and the a register
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_X,
        SEL_T,
        SEL_M,
        SEL_A,
        SEL_RP,
        SEL_RN
    } node_sel_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_IF_UNLINK,
        SEQ_IF_AFTER,
        SEQ_END
    } seq_t;

    typedef struct packed {
        logic      rd_en;
        node_sel_t rd_sel;
        logic      pw_en;
        node_sel_t pw_addr;
        node_sel_t pw_data;
        logic      nw_en;
        node_sel_t nw_addr;
        node_sel_t nw_data;
        logic      a_en;
        node_sel_t a_sel;
        logic      out_en;
        seq_t      seq;
        step_t     target;
    } ucode_t;

    localparam step_t STEP_U_RD  = STEP_W'(0);
    localparam step_t STEP_U_NBR = STEP_W'(1);
    localparam step_t STEP_U_CLR = STEP_W'(2);
    localparam step_t STEP_S_RD  = STEP_W'(3);
    localparam step_t STEP_B_M   = STEP_W'(4);
    localparam step_t STEP_B_FIX = STEP_W'(5);
    localparam step_t STEP_A_M   = STEP_W'(6);
    localparam step_t STEP_A_FIX = STEP_W'(7);
    localparam step_t STEP_R_RD  = STEP_W'(8);
    localparam step_t STEP_R_OUT = STEP_W'(9);

    // Control program. A link write only fires when its address node is nonzero.
    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        w = '0;
        case (step)
            STEP_U_RD:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = SEL_X;
            end
            STEP_U_NBR:
            begin
                // bridge the neighbors of x over it
                w.pw_en   = 1'b1;
                w.pw_addr = SEL_RN;
                w.pw_data = SEL_RP;
                w.nw_en   = 1'b1;
                w.nw_addr = SEL_RP;
                w.nw_data = SEL_RN;
            end
            STEP_U_CLR:
            begin
                w.pw_en   = 1'b1;
                w.pw_addr = SEL_X;
                w.pw_data = SEL_ZERO;
                w.nw_en   = 1'b1;
                w.nw_addr = SEL_X;
                w.nw_data = SEL_ZERO;
                w.seq     = SEQ_IF_UNLINK;
                w.target  = STEP_R_RD;
            end
            STEP_S_RD:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = SEL_T;
                w.seq    = SEQ_IF_AFTER;
                w.target = STEP_A_M;
            end
            STEP_B_M:
            begin
                w.pw_en   = 1'b1;
                w.pw_addr = SEL_M;
                w.pw_data = SEL_RP;
                w.nw_en   = 1'b1;
                w.nw_addr = SEL_M;
                w.nw_data = SEL_T;
                w.a_en    = 1'b1;
                w.a_sel   = SEL_RP;
            end
            STEP_B_FIX:
            begin
                w.pw_en   = 1'b1;
                w.pw_addr = SEL_T;
                w.pw_data = SEL_M;
                w.nw_en   = 1'b1;
                w.nw_addr = SEL_A;
                w.nw_data = SEL_M;
                w.seq     = SEQ_GOTO;
                w.target  = STEP_R_RD;
            end
            STEP_A_M:
            begin
                w.pw_en   = 1'b1;
                w.pw_addr = SEL_M;
                w.pw_data = SEL_T;
                w.nw_en   = 1'b1;
                w.nw_addr = SEL_M;
                w.nw_data = SEL_RN;
                w.a_en    = 1'b1;
                w.a_sel   = SEL_RN;
            end
            STEP_A_FIX:
            begin
                w.pw_en   = 1'b1;
                w.pw_addr = SEL_A;
                w.pw_data = SEL_M;
                w.nw_en   = 1'b1;
                w.nw_addr = SEL_T;
                w.nw_data = SEL_M;
            end
            STEP_R_RD:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = SEL_T;
            end
            STEP_R_OUT:
            begin
                w.out_en = 1'b1;
                w.seq    = SEQ_END;
            end
            default:
            begin
                w.seq = SEQ_END;
            end
        endcase
        return w;
    endfunction

endpackage

[hdl/indexed_doubly_linked_list_core.sv]
// Indexed doubly linked list: link tables, microcoded sequencer and handshakes.
//
// Usage: requests enter on in_valid/in_ready with req_type, target_node and
// moved_node; one result per request leaves on out_valid/out_ready with
// prev_of_target, next_of_target and error. node_count is written through
// cfg_valid/cfg_ready/cfg_data (cfg_ready is always high); the user must
// write it only while idle, as the block itself does not enforce this.
// Each request runs a short microprogram over two link memories with one
// read and one write port each, one control word per cycle unless the
// output step stalls. Each link read is registered and each memory takes
// one write per step. A new request is taken only in idle, once the
// previous one has loaded its result; the next item can be taken in the
// cycle after that load. The result sits in an output register, so one
// new item is taken while a result waits; a stalled receiver then holds
// the sequencer at its output step until the waiting result is taken.
// After reset a clearing pass zeroes both tables with in_ready low;
// node_count resets to 1024.
`timescale 1ns / 1ps

module indexed_doubly_linked_list_core
    import idll_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [NODE_W-1:0] target_node,
    input  logic [NODE_W-1:0] moved_node,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NODE_W-1:0] prev_of_target,
    output logic [NODE_W-1:0] next_of_target,
    output logic              error,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NODE_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam addr_t CLR_LAST = ADDR_W'(NODE_CAPACITY - 1);

    state_t state_reg;
    step_t  step_reg;
    addr_t  clr_cnt_reg;
    node_t  node_count_reg;
    logic   out_valid_reg;
    node_t  prev_out_reg;
    node_t  next_out_reg;
    logic   error_out_reg;

    req_t   req_reg;
    logic   err_reg;
    node_t  t_reg;
    node_t  m_reg;
    node_t  x_reg;
    node_t  a_reg;
    node_t  rd_prev_reg;
    node_t  rd_next_reg;

    node_t  prev_mem [NODE_CAPACITY];
    node_t  next_mem [NODE_CAPACITY];

    ucode_t cw;
    logic   running;
    logic   clearing;
    logic   in_fire;
    logic   out_load;
    logic   stall;
    logic   is_move;
    logic   req_err;
    node_t  rd_node;
    node_t  pw_addr_n;
    node_t  pw_data_n;
    node_t  nw_addr_n;
    node_t  nw_data_n;
    node_t  a_val;
    logic   prev_we;
    logic   next_we;
    addr_t  prev_waddr;
    addr_t  next_waddr;
    node_t  prev_wdata;
    node_t  next_wdata;

    function automatic logic node_ok(node_t n, node_t cnt);
        return (n != '0) && (n <= cnt) && (32'(n) <= 32'(NODE_CAPACITY));
    endfunction

    function automatic addr_t to_addr(node_t n);
        node_t d;
        d = n - NODE_W'(1);
        return ADDR_W'(d);
    endfunction

    function automatic node_t pick(node_sel_t s, node_t x, node_t t, node_t m,
                                   node_t a, node_t rp, node_t rn);
        node_t v;
        case (s)
            SEL_X:   v = x;
            SEL_T:   v = t;
            SEL_M:   v = m;
            SEL_A:   v = a;
            SEL_RP:  v = rp;
            SEL_RN:  v = rn;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign cw        = ucode_rom(step_reg);
    assign running   = (state_reg == ST_RUN);
    assign clearing  = (state_reg == ST_CLEAR);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign is_move = (req_type == REQ_BEFORE) || (req_type == REQ_AFTER);
    assign req_err = !node_ok(target_node, node_count_reg) ||
                     (is_move && (!node_ok(moved_node, node_count_reg) ||
                                  moved_node == target_node));

    assign out_load = running && cw.out_en && (!out_valid_reg || out_ready);
    assign stall    = cw.out_en && !out_load;

    always_comb
    begin
        rd_node   = pick(cw.rd_sel, x_reg, t_reg, m_reg, a_reg, rd_prev_reg, rd_next_reg);
        pw_addr_n = pick(cw.pw_addr, x_reg, t_reg, m_reg, a_reg, rd_prev_reg, rd_next_reg);
        pw_data_n = pick(cw.pw_data, x_reg, t_reg, m_reg, a_reg, rd_prev_reg, rd_next_reg);
        nw_addr_n = pick(cw.nw_addr, x_reg, t_reg, m_reg, a_reg, rd_prev_reg, rd_next_reg);
        nw_data_n = pick(cw.nw_data, x_reg, t_reg, m_reg, a_reg, rd_prev_reg, rd_next_reg);
        a_val     = pick(cw.a_sel, x_reg, t_reg, m_reg, a_reg, rd_prev_reg, rd_next_reg);
    end

    // Clearing pass owns both write ports until it ends
    always_comb
    begin
        prev_we    = clearing || (running && cw.pw_en && pw_addr_n != '0);
        next_we    = clearing || (running && cw.nw_en && nw_addr_n != '0);
        prev_waddr = clearing ? clr_cnt_reg : to_addr(pw_addr_n);
        next_waddr = clearing ? clr_cnt_reg : to_addr(nw_addr_n);
        prev_wdata = clearing ? '0 : pw_data_n;
        next_wdata = clearing ? '0 : nw_data_n;
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (running && cw.rd_en)
        begin
            rd_prev_reg <= prev_mem[to_addr(rd_node)];
            rd_next_reg <= next_mem[to_addr(rd_node)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_t'(req_type);
            err_reg <= req_err;
            t_reg   <= target_node;
            m_reg   <= moved_node;
            // the node to unlink first
            x_reg   <= is_move ? moved_node : target_node;
        end
        if (running && cw.a_en)
        begin
            a_reg <= a_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            step_reg       <= STEP_U_RD;
            clr_cnt_reg    <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            out_valid_reg  <= 1'b0;
            prev_out_reg   <= '0;
            next_out_reg   <= '0;
            error_out_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                prev_out_reg  <= err_reg ? '0 : rd_prev_reg;
                next_out_reg  <= err_reg ? '0 : rd_next_reg;
                error_out_reg <= err_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == CLR_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_RUN;
                        if (req_err)
                        begin
                            step_reg <= STEP_R_OUT;
                        end
                        else if (req_type == REQ_QUERY)
                        begin
                            step_reg <= STEP_R_RD;
                        end
                        else
                        begin
                            step_reg <= STEP_U_RD;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (!stall)
                    begin
                        case (cw.seq)
                            SEQ_NEXT:
                            begin
                                step_reg <= step_reg + STEP_W'(1);
                            end
                            SEQ_GOTO:
                            begin
                                step_reg <= cw.target;
                            end
                            SEQ_IF_UNLINK:
                            begin
                                step_reg <= (req_reg == REQ_UNLINK) ? cw.target
                                                                    : step_reg + STEP_W'(1);
                            end
                            SEQ_IF_AFTER:
                            begin
                                step_reg <= (req_reg == REQ_AFTER) ? cw.target
                                                                   : step_reg + STEP_W'(1);
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign prev_of_target = prev_out_reg;
    assign next_of_target = next_out_reg;
    assign error          = error_out_reg;

endmodule

[hdl/idll_checker.sv]
// Port-level assertions for the linked list core, bound to the top level.
`timescale 1ns / 1ps
`include "indexed_doubly_linked_list_core_macros.svh"

module idll_checker
    import idll_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [NODE_W-1:0] prev_of_target,
    input logic [NODE_W-1:0] next_of_target,
    input logic              error
);

    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Count items taken in but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    `IDLL_ASSERT_IMPLIES(a_err_no_links, clk, rst_n, out_valid && error, prev_of_target == '0 && next_of_target == '0, "rejected item returned links")
    `IDLL_ASSERT_IMPLIES(a_no_spurious, clk, rst_n, out_valid, pend_reg != 2'd0, "result without an accepted item")
    `IDLL_ASSERT_IMPLIES(a_one_in_work, clk, rst_n, in_acc, pend_reg <= 2'd1, "item accepted while another is in work")
    `IDLL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(prev_of_target) && $stable(next_of_target) && $stable(error), "stalled result changed")

endmodule

bind indexed_doubly_linked_list_core idll_checker u_idll_checker (.*);

[tb/sv/indexed_doubly_linked_list_core_test.sv]
// Testbench for the linked list core: directed and random link requests checked against a predictor.
`timescale 1ns / 1ps

module indexed_doubly_linked_list_core_test;
    import idll_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        req_t  kind;
        node_t target;
        node_t moved;
        logic  drain_first;
    } link_req_t;

    typedef struct packed {
        node_t prev;
        node_t next;
        logic  err;
    } link_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    node_t       target_node = '0;
    node_t       moved_node = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    node_t       prev_of_target;
    node_t       next_of_target;
    logic        error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    node_t       cfg_data = '0;

    // Predictor state
    node_t       prev_tbl [0:NODE_CAPACITY];
    node_t       next_tbl [0:NODE_CAPACITY];
    node_t       node_limit = NODE_COUNT_RESET;

    link_req_t   issue_q [$];
    link_res_t   link_results_q [$];
    link_req_t   cur_req;
    link_res_t   want;

    int unsigned tx_count = 0;
    int unsigned rx_count = 0;
    int          mism_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          stall_mode = 0;
    int unsigned cycle_count = 0;

    indexed_doubly_linked_list_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .target_node    (target_node),
        .moved_node     (moved_node),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .prev_of_target (prev_of_target),
        .next_of_target (next_of_target),
        .error          (error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i <= NODE_CAPACITY; i++)
        begin
            prev_tbl[i] = '0;
            next_tbl[i] = '0;
        end
    end

    function automatic logic node_ok(node_t idx);
        return idx != 0 && idx <= node_limit && int'(idx) <= NODE_CAPACITY;
    endfunction

    function automatic void detach(node_t x);
        node_t p;
        node_t n;
        p = prev_tbl[x];
        n = next_tbl[x];
        if (p != 0)
            next_tbl[p] = n;
        if (n != 0)
            prev_tbl[n] = p;
        prev_tbl[x] = '0;
        next_tbl[x] = '0;
    endfunction

    // Splice lone node m between p and n; either neighbor may be empty.
    function automatic void splice_in(node_t m, node_t p, node_t n);
        prev_tbl[m] = p;
        next_tbl[m] = n;
        if (p != 0)
            next_tbl[p] = m;
        if (n != 0)
            prev_tbl[n] = m;
    endfunction

    function automatic link_res_t apply_request(link_req_t rq);
        link_res_t rs;
        node_t     t;
        node_t     m;
        logic      bad;
        rs = '0;
        t = rq.target;
        m = rq.moved;
        bad = !node_ok(t);
        if (!bad && (rq.kind == REQ_BEFORE || rq.kind == REQ_AFTER))
            bad = !node_ok(m) || m == t;
        if (bad)
        begin
            rs.err = 1'b1;
            return rs;
        end
        case (rq.kind)
            REQ_UNLINK:
                detach(t);
            REQ_BEFORE:
            begin
                detach(m);
                splice_in(m, prev_tbl[t], t);
            end
            REQ_AFTER:
            begin
                detach(m);
                splice_in(m, t, next_tbl[t]);
            end
            default:
                ;
        endcase
        rs.prev = prev_tbl[t];
        rs.next = next_tbl[t];
        return rs;
    endfunction

    // Boundary and out-of-range indexes
    function automatic node_t odd_node();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return node_limit;
            2: return node_limit + 1'b1;
            3: return node_t'(1024);
            4: return node_t'(1025);
            default: return node_t'($urandom_range(0, 2047));
        endcase
    endfunction

    // Mostly a small pool so that lists grow long, some at the top of the range.
    function automatic node_t pick_node();
        int eff;
        int r;
        eff = (int'(node_limit) > NODE_CAPACITY) ? NODE_CAPACITY : int'(node_limit);
        r = $urandom_range(0, 99);
        if (eff == 0 || r < 12)
            return odd_node();
        if (r < 62)
            return node_t'($urandom_range(1, eff < 12 ? eff : 12));
        if (r < 80)
            return node_t'($urandom_range(eff > 12 ? eff - 11 : 1, eff));
        return node_t'($urandom_range(1, eff));
    endfunction

    function automatic link_req_t rand_req();
        link_req_t rq;
        int        r;
        r = $urandom_range(0, 99);
        rq.kind = r < 15 ? REQ_UNLINK : r < 45 ? REQ_BEFORE : r < 75 ? REQ_AFTER : REQ_QUERY;
        rq.target = pick_node();
        rq.moved = pick_node();
        if (rq.moved == rq.target && $urandom_range(0, 7) != 0)
            rq.moved = pick_node();
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    task automatic add_req(req_t kind, int t, int m);
        link_req_t rq;
        rq.kind = kind;
        rq.target = node_t'(t);
        rq.moved = node_t'(m);
        rq.drain_first = 1'b0;
        issue_q.push_back(rq);
    endtask

    task automatic random_phase(int count);
        link_req_t rq;
        for (int i = 0; i < count; i++)
        begin
            rq = rand_req();
            // hold the sender mid-phase until every result is back
            rq.drain_first = (i == count / 2) || ($urandom_range(0, 99) == 0);
            issue_q.push_back(rq);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (issue_q.size() != 0 || in_valid || link_results_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(node_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        node_limit = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            link_results_q.push_back(apply_request(cur_req));
            tx_count <= tx_count + 1;
        end
        if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (!rst_n || issue_q.size() == 0 ||
                     (issue_q[0].drain_first && (in_valid || tx_count != rx_count)))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                cur_req = issue_q.pop_front();
                in_valid <= 1'b1;
                req_type <= cur_req.kind;
                target_node <= cur_req.target;
                moved_node <= cur_req.moved;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 12);
                end
            end
        end
    end

    // Receiver: check each result, then stall on a pattern of stretches
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            rx_count <= rx_count + 1;
            if (link_results_q.size() == 0)
            begin
                $display("%0t: unexpected result prev %0d next %0d error %0b",
                         $time, prev_of_target, next_of_target, error);
                mism_count = mism_count + 1;
            end
            else
            begin
                want = link_results_q.pop_front();
                if (prev_of_target !== want.prev)
                begin
                    $display("%0t: prev_of_target expected %0d actual %0d",
                             $time, want.prev, prev_of_target);
                    mism_count = mism_count + 1;
                end
                if (next_of_target !== want.next)
                begin
                    $display("%0t: next_of_target expected %0d actual %0d",
                             $time, want.next, next_of_target);
                    mism_count = mism_count + 1;
                end
                if (error !== want.err)
                begin
                    $display("%0t: error expected %0b actual %0b", $time, want.err, error);
                    mism_count = mism_count + 1;
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 120);
        end
        else
        begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL indexed_doubly_linked_list_core");
            $finish;
        end
    end

    initial
    begin
        int unsigned limits [8] = '{8, 1, 0, 2047, 1024, 300, 3, 16};
        int          counts [8] = '{160, 40, 20, 160, 220, 160, 110, 160};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset node count
        add_req(REQ_QUERY, 1, 0);
        add_req(REQ_QUERY, 1024, 2047);
        add_req(REQ_QUERY, 0, 0);
        add_req(REQ_QUERY, 1025, 0);
        add_req(REQ_QUERY, 2047, 0);
        add_req(REQ_AFTER, 1, 1024);
        add_req(REQ_BEFORE, 1024, 2);
        add_req(REQ_AFTER, 1024, 1023);
        add_req(REQ_BEFORE, 1, 1);
        add_req(REQ_BEFORE, 2, 0);
        add_req(REQ_AFTER, 2, 1025);
        add_req(REQ_AFTER, 2, 2047);
        add_req(REQ_BEFORE, 0, 5);
        add_req(REQ_AFTER, 1025, 5);
        add_req(REQ_BEFORE, 2, 1);
        add_req(REQ_AFTER, 1023, 1);
        add_req(REQ_UNLINK, 500, 0);
        add_req(REQ_UNLINK, 1024, 0);
        add_req(REQ_UNLINK, 2, 0);
        add_req(REQ_UNLINK, 1, 0);
        add_req(REQ_UNLINK, 0, 0);
        add_req(REQ_AFTER, 3, 1023);
        add_req(REQ_AFTER, 1023, 3);
        add_req(REQ_QUERY, 1023, 1023);
        add_req(REQ_QUERY, 3, 0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_limit(node_t'(limits[ph]));
            random_phase(counts[ph]);
            wait_idle();
        end

        if (mism_count == 0)
            $display("PASS indexed_doubly_linked_list_core");
        else
            $display("FAIL indexed_doubly_linked_list_core");
        $finish;
    end

endmodule
